@@ hw/rtl/emssc_pkg.sv @@
package emssc_pkg;

  typedef enum logic [2:0] {
    SCR_MAIN      = 3'd0,
    SCR_MANUAL    = 3'd1,
    SCR_SET_MIN   = 3'd2,
    SCR_SET_MAX   = 3'd3,
    SCR_SET_SPEED = 3'd4,
    SCR_SWEEP     = 3'd5,
    SCR_PAUSED    = 3'd6
  } screen_t;

  localparam logic CFG_ALARM_LOW  = 1'b0;
  localparam logic CFG_ALARM_HIGH = 1'b1;

  localparam logic [7:0] ANGLE_MAX      = 8'd180;
  localparam logic [7:0] MANUAL_HOME    = 8'd90;
  localparam logic [7:0] ALARM_LOW_RST  = 8'd50;
  localparam logic [7:0] ALARM_HIGH_RST = 8'd110;

  localparam logic [6:0] MIN_LO   = 7'd50;
  localparam logic [6:0] MIN_HI   = 7'd70;
  localparam logic [6:0] MAX_LO   = 7'd95;
  localparam logic [6:0] MAX_HI   = 7'd110;
  localparam logic [6:0] SPEED_LO = 7'd10;
  localparam logic [6:0] SPEED_HI = 7'd100;
  localparam logic [6:0] MIN_RST   = 7'd60;
  localparam logic [6:0] MAX_RST   = 7'd100;
  localparam logic [6:0] SPEED_RST = 7'd15;
  localparam logic [6:0] MS_SAT    = 7'd127;
  localparam logic signed [9:0] SETTING_STEP = 10'sd5;

  typedef struct packed {
    logic signed [1:0] step;
    logic              click;
    logic              tick;
  } in_word_t;

  typedef struct packed {
    logic [2:0] screen;
    logic       selection;
    logic [7:0] servo_angle;
    logic       servo_write;
    logic       alarm;
    logic [6:0] therapy_min;
    logic [6:0] therapy_max;
    logic [6:0] therapy_speed;
    logic [7:0] manual_angle;
  } out_word_t;

endpackage

@@ hw/rtl/encoder_menu_servo_sweep_controller_unit.sv @@
// Menu and servo sweep controller. Each input word is one encoder poll (step,
// click, millisecond tick) and yields exactly one result word in the cycle after
// it is accepted. All screen logic sits between the state registers and a
// single result register, so a new poll is taken every cycle while the output
// side keeps up; when a result is stalled, in_ready drops until it is taken.
// alarm_low and alarm_high may be rewritten through the cfg port at any time
// the block is idle; they take effect on the next commanded servo angle.
module encoder_menu_servo_sweep_controller_unit #(
  parameter logic [7:0] CENTER_ANGLE = 8'd90
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  emssc_pkg::in_word_t  in_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output emssc_pkg::out_word_t out_word,
  input  logic                 cfg_we,
  input  logic                 cfg_addr,
  input  logic [7:0]           cfg_wdata
);

  // Adds a signed delta to a value and clamps the sum into lo..hi.
  function automatic logic [7:0] clamp_add(input logic [7:0] val,
                                           input logic signed [9:0] delta,
                                           input logic [7:0] lo,
                                           input logic [7:0] hi);
    logic signed [9:0] sum;
    sum = $signed({2'b00, val}) + delta;
    if (sum < $signed({2'b00, lo})) begin
      return lo;
    end else if (sum > $signed({2'b00, hi})) begin
      return hi;
    end else begin
      return sum[7:0];
    end
  endfunction

  emssc_pkg::screen_t screen_r, screen_nxt;
  logic       choice_r, choice_nxt;
  logic [7:0] manual_r, manual_nxt;
  logic [6:0] low_r, low_nxt;
  logic [6:0] high_r, high_nxt;
  logic [6:0] period_r, period_nxt;
  logic [7:0] pos_r, pos_nxt;
  logic       rising_r, rising_nxt;
  logic [6:0] ms_r, ms_nxt;
  logic       alarm_r, alarm_nxt;
  logic [7:0] servo_r, servo_nxt;
  logic [7:0] alarm_lo_r, alarm_hi_r;
  logic       out_valid_r;
  emssc_pkg::out_word_t out_word_r, out_word_nxt;

  logic              accept;
  logic              moved;
  logic signed [9:0] step_one;
  logic signed [9:0] step_five;
  logic [6:0]        ms_cnt;
  logic              wrote;
  logic [7:0]        low_sum;
  logic [7:0]        high_sum;
  logic [7:0]        period_sum;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // The unused step code 2'b10 counts as a backward step.
  assign moved     = (in_word.step != 2'sd0);
  assign step_one  = (in_word.step == 2'sd1) ? 10'sd1 : -10'sd1;
  assign step_five = (in_word.step == 2'sd1) ? emssc_pkg::SETTING_STEP
                                             : -emssc_pkg::SETTING_STEP;
  assign ms_cnt    = (in_word.tick && ms_r != emssc_pkg::MS_SAT) ? ms_r + 7'd1 : ms_r;

  assign low_sum    = clamp_add({1'b0, low_r}, step_five, {1'b0, emssc_pkg::MIN_LO},
                                {1'b0, emssc_pkg::MIN_HI});
  assign high_sum   = clamp_add({1'b0, high_r}, step_five, {1'b0, emssc_pkg::MAX_LO},
                                {1'b0, emssc_pkg::MAX_HI});
  assign period_sum = clamp_add({1'b0, period_r}, step_five,
                                {1'b0, emssc_pkg::SPEED_LO},
                                {1'b0, emssc_pkg::SPEED_HI});

  always_comb begin
    screen_nxt = screen_r;
    choice_nxt = choice_r;
    manual_nxt = manual_r;
    low_nxt    = low_r;
    high_nxt   = high_r;
    period_nxt = period_r;
    pos_nxt    = pos_r;
    rising_nxt = rising_r;
    ms_nxt     = ms_cnt;
    alarm_nxt  = alarm_r;
    servo_nxt  = servo_r;
    wrote      = 1'b0;
    case (screen_r)
      emssc_pkg::SCR_MANUAL: begin
        if (moved) begin
          manual_nxt = clamp_add(manual_r, step_one, 8'd0, emssc_pkg::ANGLE_MAX);
          servo_nxt  = manual_nxt;
          alarm_nxt  = (manual_nxt < alarm_lo_r) || (manual_nxt > alarm_hi_r);
          wrote      = 1'b1;
        end
        if (in_word.click) begin
          alarm_nxt  = 1'b0;
          screen_nxt = emssc_pkg::SCR_MAIN;
          choice_nxt = 1'b0;
          manual_nxt = emssc_pkg::MANUAL_HOME;
        end
      end
      emssc_pkg::SCR_SET_MIN: begin
        if (moved) begin
          low_nxt = low_sum[6:0];
        end
        if (in_word.click) begin
          screen_nxt = emssc_pkg::SCR_SET_MAX;
        end
      end
      emssc_pkg::SCR_SET_MAX: begin
        if (moved) begin
          high_nxt = high_sum[6:0];
        end
        if (in_word.click) begin
          screen_nxt = emssc_pkg::SCR_SET_SPEED;
        end
      end
      emssc_pkg::SCR_SET_SPEED: begin
        if (moved) begin
          period_nxt = period_sum[6:0];
        end
        if (in_word.click) begin
          screen_nxt = emssc_pkg::SCR_SWEEP;
          pos_nxt    = CENTER_ANGLE;
          rising_nxt = 1'b1;
          ms_nxt     = 7'd0;
        end
      end
      emssc_pkg::SCR_SWEEP: begin
        if (ms_cnt >= period_r) begin
          ms_nxt  = 7'd0;
          pos_nxt = clamp_add(pos_r, rising_r ? 10'sd1 : -10'sd1, 8'd0,
                              emssc_pkg::ANGLE_MAX);
          if (pos_nxt >= {1'b0, high_r}) begin
            rising_nxt = 1'b0;
          end
          if (pos_nxt <= {1'b0, low_r}) begin
            rising_nxt = 1'b1;
          end
          servo_nxt = pos_nxt;
          alarm_nxt = (pos_nxt < alarm_lo_r) || (pos_nxt > alarm_hi_r);
          wrote     = 1'b1;
        end
        if (in_word.click) begin
          alarm_nxt  = 1'b0;
          screen_nxt = emssc_pkg::SCR_PAUSED;
          choice_nxt = 1'b0;
        end
      end
      emssc_pkg::SCR_PAUSED: begin
        if (moved) begin
          choice_nxt = !choice_r;
        end
        if (in_word.click) begin
          if (!choice_nxt) begin
            screen_nxt = emssc_pkg::SCR_SWEEP;
          end else begin
            screen_nxt = emssc_pkg::SCR_MAIN;
            choice_nxt = 1'b0;
          end
        end
      end
      default: begin
        // Main menu; an unused screen code behaves the same way.
        if (moved) begin
          choice_nxt = !choice_r;
        end
        if (in_word.click) begin
          screen_nxt = choice_nxt ? emssc_pkg::SCR_SET_MIN : emssc_pkg::SCR_MANUAL;
        end
      end
    endcase

    out_word_nxt.screen        = screen_nxt;
    out_word_nxt.selection     = choice_nxt;
    out_word_nxt.servo_angle   = servo_nxt;
    out_word_nxt.servo_write   = wrote;
    out_word_nxt.alarm         = alarm_nxt;
    out_word_nxt.therapy_min   = low_nxt;
    out_word_nxt.therapy_max   = high_nxt;
    out_word_nxt.therapy_speed = period_nxt;
    out_word_nxt.manual_angle  = manual_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_r    <= emssc_pkg::SCR_MAIN;
      choice_r    <= 1'b0;
      manual_r    <= emssc_pkg::MANUAL_HOME;
      low_r       <= emssc_pkg::MIN_RST;
      high_r      <= emssc_pkg::MAX_RST;
      period_r    <= emssc_pkg::SPEED_RST;
      pos_r       <= CENTER_ANGLE;
      rising_r    <= 1'b1;
      ms_r        <= 7'd0;
      alarm_r     <= 1'b0;
      servo_r     <= CENTER_ANGLE;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        screen_r <= screen_nxt;
        choice_r <= choice_nxt;
        manual_r <= manual_nxt;
        low_r    <= low_nxt;
        high_r   <= high_nxt;
        period_r <= period_nxt;
        pos_r    <= pos_nxt;
        rising_r <= rising_nxt;
        ms_r     <= ms_nxt;
        alarm_r  <= alarm_nxt;
        servo_r  <= servo_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alarm_lo_r <= emssc_pkg::ALARM_LOW_RST;
      alarm_hi_r <= emssc_pkg::ALARM_HIGH_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        emssc_pkg::CFG_ALARM_LOW:  alarm_lo_r <= cfg_wdata;
        emssc_pkg::CFG_ALARM_HIGH: alarm_hi_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_word_r <= out_word_nxt;
    end
  end

endmodule

@@ hw/rtl/emssc_checker.sv @@
module emssc_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input emssc_pkg::out_word_t out_word
);

  // A stalled result word must hold still.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  // With no result pending the block must take input.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output register");

  // Setting screens never command the servo.
  a_no_write_in_setup: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.servo_write |->
      out_word.screen != emssc_pkg::SCR_SET_MIN &&
      out_word.screen != emssc_pkg::SCR_SET_MAX &&
      out_word.screen != emssc_pkg::SCR_SET_SPEED)
    else $error("servo written on a setting screen");

  // Sweep settings stay inside their clamp ranges.
  a_settings_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      out_word.therapy_min >= emssc_pkg::MIN_LO &&
      out_word.therapy_min <= emssc_pkg::MIN_HI &&
      out_word.therapy_max >= emssc_pkg::MAX_LO &&
      out_word.therapy_max <= emssc_pkg::MAX_HI &&
      out_word.therapy_speed >= emssc_pkg::SPEED_LO &&
      out_word.therapy_speed <= emssc_pkg::SPEED_HI)
    else $error("sweep setting out of range");

  // An input accepted with room downstream shows up as a result next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted word produced no result");

endmodule

bind encoder_menu_servo_sweep_controller_unit emssc_checker u_emssc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word)
);

@@ bench/emssc_sweep_checker.sv @@
`timescale 1ns / 1ps

module emssc_sweep_checker #(
  parameter logic [7:0] CENTER_ANGLE = 8'd90
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  emssc_pkg::in_word_t  in_word,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  emssc_pkg::out_word_t out_word,
  input  logic                 cfg_we,
  input  logic                 cfg_addr,
  input  logic [7:0]           cfg_wdata,
  output int                   mismatch_count,
  output int                   expected_left,
  output int                   results_seen
);

  // Shadow of the controller state.
  emssc_pkg::screen_t scr;
  logic       sel;
  logic [7:0] manual_pos;
  logic [7:0] sweep_pos;
  logic [7:0] servo_last;
  logic [7:0] alarm_lo_thr;
  logic [7:0] alarm_hi_thr;
  logic [6:0] min_deg;
  logic [6:0] max_deg;
  logic [6:0] period_ms;
  logic [6:0] ms_count;
  logic       rising;
  logic       alarm_level;

  emssc_pkg::out_word_t predicted_status[$];

  function automatic int clamp_to(input int v, input int lo, input int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic string show(input emssc_pkg::out_word_t s);
    return $sformatf("scr=%0d sel=%0d servo=%0d wr=%0d alm=%0d min=%0d max=%0d per=%0d man=%0d",
                     s.screen, s.selection, s.servo_angle, s.servo_write, s.alarm,
                     s.therapy_min, s.therapy_max, s.therapy_speed, s.manual_angle);
  endfunction

  function automatic string differing_fields(input emssc_pkg::out_word_t want,
                                             input emssc_pkg::out_word_t got);
    string s;
    s = "";
    if (got.screen !== want.screen) s = {s, " screen"};
    if (got.selection !== want.selection) s = {s, " selection"};
    if (got.servo_angle !== want.servo_angle) s = {s, " servo_angle"};
    if (got.servo_write !== want.servo_write) s = {s, " servo_write"};
    if (got.alarm !== want.alarm) s = {s, " alarm"};
    if (got.therapy_min !== want.therapy_min) s = {s, " therapy_min"};
    if (got.therapy_max !== want.therapy_max) s = {s, " therapy_max"};
    if (got.therapy_speed !== want.therapy_speed) s = {s, " therapy_speed"};
    if (got.manual_angle !== want.manual_angle) s = {s, " manual_angle"};
    return s;
  endfunction

  task automatic reset_controller();
    scr = emssc_pkg::SCR_MAIN;
    sel = 1'b0;
    manual_pos = emssc_pkg::MANUAL_HOME;
    sweep_pos = CENTER_ANGLE;
    servo_last = CENTER_ANGLE;
    alarm_lo_thr = emssc_pkg::ALARM_LOW_RST;
    alarm_hi_thr = emssc_pkg::ALARM_HIGH_RST;
    min_deg = emssc_pkg::MIN_RST;
    max_deg = emssc_pkg::MAX_RST;
    period_ms = emssc_pkg::SPEED_RST;
    ms_count = '0;
    rising = 1'b1;
    alarm_level = 1'b0;
  endtask

  task automatic command_servo(input logic [7:0] angle);
    servo_last = angle;
    alarm_level = (angle < alarm_lo_thr) || (angle > alarm_hi_thr);
  endtask

  task automatic poll_controller(input emssc_pkg::in_word_t w,
                                 output emssc_pkg::out_word_t r);
    int   dir;
    int   delta;
    logic moved;
    // The unused encoding of the step field counts as a step back.
    dir = (w.step == 2'sb01) ? 1 : ((w.step == 2'sb00) ? 0 : -1);
    delta = dir * int'(emssc_pkg::SETTING_STEP);
    moved = 1'b0;
    if (w.tick && ms_count != emssc_pkg::MS_SAT) ms_count = ms_count + 7'd1;
    case (scr)
      emssc_pkg::SCR_MANUAL: begin
        if (dir != 0) begin
          manual_pos = 8'(clamp_to(int'(manual_pos) + dir, 0,
                                   int'(emssc_pkg::ANGLE_MAX)));
          command_servo(manual_pos);
          moved = 1'b1;
        end
        if (w.click) begin
          alarm_level = 1'b0;
          scr = emssc_pkg::SCR_MAIN;
          sel = 1'b0;
          manual_pos = emssc_pkg::MANUAL_HOME;
        end
      end
      emssc_pkg::SCR_SET_MIN: begin
        if (dir != 0) begin
          min_deg = 7'(clamp_to(int'(min_deg) + delta, int'(emssc_pkg::MIN_LO),
                                int'(emssc_pkg::MIN_HI)));
        end
        if (w.click) scr = emssc_pkg::SCR_SET_MAX;
      end
      emssc_pkg::SCR_SET_MAX: begin
        if (dir != 0) begin
          max_deg = 7'(clamp_to(int'(max_deg) + delta, int'(emssc_pkg::MAX_LO),
                                int'(emssc_pkg::MAX_HI)));
        end
        if (w.click) scr = emssc_pkg::SCR_SET_SPEED;
      end
      emssc_pkg::SCR_SET_SPEED: begin
        if (dir != 0) begin
          period_ms = 7'(clamp_to(int'(period_ms) + delta, int'(emssc_pkg::SPEED_LO),
                                  int'(emssc_pkg::SPEED_HI)));
        end
        if (w.click) begin
          scr = emssc_pkg::SCR_SWEEP;
          sweep_pos = CENTER_ANGLE;
          rising = 1'b1;
          ms_count = '0;
        end
      end
      emssc_pkg::SCR_SWEEP: begin
        if (ms_count >= period_ms) begin
          ms_count = '0;
          sweep_pos = 8'(clamp_to(int'(sweep_pos) + (rising ? 1 : -1), 0,
                                  int'(emssc_pkg::ANGLE_MAX)));
          if (sweep_pos >= {1'b0, max_deg}) rising = 1'b0;
          if (sweep_pos <= {1'b0, min_deg}) rising = 1'b1;
          command_servo(sweep_pos);
          moved = 1'b1;
        end
        if (w.click) begin
          alarm_level = 1'b0;
          scr = emssc_pkg::SCR_PAUSED;
          sel = 1'b0;
        end
      end
      emssc_pkg::SCR_PAUSED: begin
        if (dir != 0) sel = ~sel;
        if (w.click) begin
          if (!sel) begin
            scr = emssc_pkg::SCR_SWEEP;
          end else begin
            scr = emssc_pkg::SCR_MAIN;
            sel = 1'b0;
          end
        end
      end
      default: begin
        if (dir != 0) sel = ~sel;
        if (w.click) scr = sel ? emssc_pkg::SCR_SET_MIN : emssc_pkg::SCR_MANUAL;
      end
    endcase
    r.screen = scr;
    r.selection = sel;
    r.servo_angle = servo_last;
    r.servo_write = moved;
    r.alarm = alarm_level;
    r.therapy_min = min_deg;
    r.therapy_max = max_deg;
    r.therapy_speed = period_ms;
    r.manual_angle = manual_pos;
  endtask

  always @(posedge clk) begin : watch
    emssc_pkg::out_word_t want;
    string     diff;
    if (!rst_n) begin
      reset_controller();
      predicted_status.delete();
      mismatch_count = 0;
      results_seen = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_addr == emssc_pkg::CFG_ALARM_LOW) alarm_lo_thr = cfg_wdata;
        else alarm_hi_thr = cfg_wdata;
      end
      if (in_valid && in_ready) begin
        poll_controller(in_word, want);
        predicted_status.push_back(want);
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (predicted_status.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: result word with none expected: %s", $realtime, show(out_word));
          end
        end else begin
          want = predicted_status.pop_front();
          diff = differing_fields(want, out_word);
          if (diff != "") begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("%0t: result %0d differs in%s", $realtime, results_seen, diff);
              $display("  expected %s", show(want));
              $display("  actual   %s", show(out_word));
            end
          end
        end
      end
    end
    expected_left = predicted_status.size();
  end

endmodule

@@ bench/tb_encoder_menu_servo_sweep_controller_unit.sv @@
`timescale 1ns / 1ps

module tb_encoder_menu_servo_sweep_controller_unit;

  localparam logic [7:0] CENTER = 8'd90;
  localparam int PHASES = 6;
  localparam int DIRECTED_POLLS = 25;
  localparam int RANDOM_POLLS = 800;
  localparam int SINK_HOLD_CYCLES = 60;
  localparam int DRAIN_LIMIT = 2000;
  localparam int TIMEOUT_NS = 4_000_000;

  localparam logic signed [1:0] STEP_NONE = 2'sb00;
  localparam logic signed [1:0] STEP_FWD = 2'sb01;
  localparam logic signed [1:0] STEP_BACK = 2'sb11;
  localparam logic signed [1:0] STEP_ALT_BACK = 2'sb10;

  typedef enum int {SET_RANDOM, SET_FLOOR, SET_CEILING, SET_NARROW_FAST} setting_plan_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  emssc_pkg::in_word_t  in_word;
  logic                 out_valid;
  logic                 out_ready;
  emssc_pkg::out_word_t out_word;
  logic                 cfg_we;
  logic                 cfg_addr;
  logic [7:0]           cfg_wdata;

  int mismatch_count;
  int expected_left;
  int results_seen;

  // Screen and selection as seen by the stimulus, used only to steer it.
  emssc_pkg::screen_t nav_screen;
  logic    nav_sel;
  logic    gapless;
  logic    sink_hold_req;
  int      polls_sent;
  int      alarm_settings;

  always #2 clk = ~clk;

  encoder_menu_servo_sweep_controller_unit #(.CENTER_ANGLE(CENTER)) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word (out_word),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  emssc_sweep_checker #(.CENTER_ANGLE(CENTER)) i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_word       (in_word),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_word      (out_word),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .mismatch_count(mismatch_count),
    .expected_left (expected_left),
    .results_seen  (results_seen)
  );

  function automatic logic chance(input int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic logic coin();
    return chance(50);
  endfunction

  function automatic int idle_length();
    int r;
    if (gapless) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic signed [1:0] step_code(input int dir);
    if (dir > 0) return STEP_FWD;
    if (dir < 0) return coin() ? STEP_BACK : STEP_ALT_BACK;
    return STEP_NONE;
  endfunction

  function automatic logic signed [1:0] random_step();
    return step_code(int'($urandom_range(0, 2)) - 1);
  endfunction

  function automatic void track_screen(input logic moved, input logic ck);
    case (nav_screen)
      emssc_pkg::SCR_MANUAL: if (ck) begin
        nav_screen = emssc_pkg::SCR_MAIN;
        nav_sel = 1'b0;
      end
      emssc_pkg::SCR_SET_MIN: if (ck) nav_screen = emssc_pkg::SCR_SET_MAX;
      emssc_pkg::SCR_SET_MAX: if (ck) nav_screen = emssc_pkg::SCR_SET_SPEED;
      emssc_pkg::SCR_SET_SPEED: if (ck) nav_screen = emssc_pkg::SCR_SWEEP;
      emssc_pkg::SCR_SWEEP: if (ck) begin
        nav_screen = emssc_pkg::SCR_PAUSED;
        nav_sel = 1'b0;
      end
      emssc_pkg::SCR_PAUSED: begin
        if (moved) nav_sel = ~nav_sel;
        if (ck) begin
          if (nav_sel) begin
            nav_screen = emssc_pkg::SCR_MAIN;
            nav_sel = 1'b0;
          end else begin
            nav_screen = emssc_pkg::SCR_SWEEP;
          end
        end
      end
      default: begin
        if (moved) nav_sel = ~nav_sel;
        if (ck) nav_screen = nav_sel ? emssc_pkg::SCR_SET_MIN : emssc_pkg::SCR_MANUAL;
      end
    endcase
  endfunction

  task automatic send_poll(input logic signed [1:0] st, input logic ck, input logic tk);
    int                  gap;
    emssc_pkg::in_word_t w;
    gap = idle_length();
    w.step = st;
    w.click = ck;
    w.tick = tk;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    polls_sent++;
    track_screen(st != STEP_NONE, ck);
  endtask

  task automatic wait_all_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_left != 0) @(negedge clk);
  endtask

  task automatic write_alarm_limits(input logic [7:0] lo, input logic [7:0] hi);
    wait_all_results();
    repeat (2) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= emssc_pkg::CFG_ALARM_LOW;
    cfg_wdata <= lo;
    @(negedge clk);
    cfg_addr <= emssc_pkg::CFG_ALARM_HIGH;
    cfg_wdata <= hi;
    @(negedge clk);
    cfg_we <= 1'b0;
    alarm_settings++;
  endtask

  task automatic return_to_main();
    while (nav_screen != emssc_pkg::SCR_MAIN) begin
      // On the pause menu the step is applied before the click, so this lands on main.
      if (nav_screen == emssc_pkg::SCR_PAUSED && !nav_sel) begin
        send_poll(STEP_FWD, 1'b1, coin());
      end else begin
        send_poll(STEP_NONE, 1'b1, coin());
      end
    end
  endtask

  task automatic open_screen(input emssc_pkg::screen_t target);
    logic want_sel;
    return_to_main();
    want_sel = (target == emssc_pkg::SCR_SET_MIN);
    send_poll(nav_sel != want_sel ? step_code(coin() ? 1 : -1) : STEP_NONE, 1'b1, coin());
  endtask

  task automatic manual_run(input int n, input int dir, input int bias_pct);
    open_screen(emssc_pkg::SCR_MANUAL);
    repeat (n) send_poll(chance(bias_pct) ? step_code(dir) : random_step(), 1'b0, coin());
    send_poll(random_step(), 1'b1, coin());
  endtask

  task automatic settings_run(input setting_plan_t plan);
    int idx;
    int n;
    int dir;
    open_screen(emssc_pkg::SCR_SET_MIN);
    for (idx = 0; idx < 3; idx++) begin
      case (plan)
        SET_FLOOR: dir = -1;
        SET_CEILING: dir = 1;
        SET_NARROW_FAST: dir = (idx == 0) ? 1 : -1;
        default: dir = 0;
      endcase
      n = (plan == SET_RANDOM) ? $urandom_range(0, 5) : ((idx == 2) ? 20 : 6);
      repeat (n) send_poll(dir == 0 ? random_step() : step_code(dir), 1'b0, coin());
      send_poll(plan == SET_RANDOM ? random_step() : STEP_NONE, 1'b1, coin());
    end
  endtask

  task automatic sweep_run(input int n, input int tick_pct, input logic clicks_ok);
    if (nav_screen == emssc_pkg::SCR_PAUSED) begin
      send_poll(nav_sel ? STEP_FWD : STEP_NONE, 1'b1, coin());
    end else if (nav_screen != emssc_pkg::SCR_SWEEP) begin
      settings_run(SET_RANDOM);
    end
    repeat (n) begin
      send_poll(random_step(), clicks_ok && ($urandom_range(0, 29) == 0), chance(tick_pct));
    end
  endtask

  // A long pause with a tick on every word drives the millisecond count into saturation.
  task automatic pause_soak();
    sweep_run(3, 100, 1'b0);
    send_poll(STEP_NONE, 1'b1, 1'b1);
    repeat (135) send_poll(random_step(), 1'b0, 1'b1);
    send_poll(nav_sel ? STEP_FWD : STEP_NONE, 1'b1, 1'b1);
    sweep_run(15, 100, 1'b0);
  endtask

  task automatic noise_run(input int n);
    repeat (n) send_poll(random_step(), coin(), coin());
  endtask

  // The sink holds off while words keep coming, so the block backs up and drops in_ready.
  task automatic squeeze_output();
    gapless = 1'b1;
    sink_hold_req = 1'b1;
    repeat (12) send_poll(random_step(), coin(), coin());
    gapless = 1'b0;
    wait_all_results();
  endtask

  task automatic run_random_sequence();
    gapless = ($urandom_range(0, 4) == 0);
    case ($urandom_range(0, 9))
      0, 1: manual_run($urandom_range(1, 25), coin() ? 1 : -1, 70);
      2, 3: settings_run(setting_plan_t'($urandom_range(0, 3)));
      4, 5, 6: sweep_run($urandom_range(5, 60), $urandom_range(40, 100), 1'b1);
      7: noise_run($urandom_range(1, 20));
      default: begin
        settings_run(SET_NARROW_FAST);
        sweep_run($urandom_range(20, 80), 100, 1'b1);
      end
    endcase
    gapless = 1'b0;
  endtask

  initial begin : result_sink
    int hold_left;
    int run_left;
    hold_left = 0;
    run_left = 0;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (sink_hold_req) begin
        out_ready <= 1'b0;
        repeat (SINK_HOLD_CYCLES) @(negedge clk);
        sink_hold_req = 1'b0;
      end else if (hold_left > 0 && !gapless) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= 1'b1;
        if (run_left > 0) begin
          run_left--;
        end else begin
          run_left = $urandom_range(0, 12);
          hold_left = idle_length();
        end
      end
    end
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("tb_encoder_menu_servo_sweep_controller_unit failed");
    $finish;
  end

  initial begin : stimulus
    int phase;
    int quota;
    int waited;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    cfg_we = 1'b0;
    cfg_addr = emssc_pkg::CFG_ALARM_LOW;
    cfg_wdata = '0;
    gapless = 1'b0;
    sink_hold_req = 1'b0;
    nav_screen = emssc_pkg::SCR_MAIN;
    nav_sel = 1'b0;
    polls_sent = 0;
    alarm_settings = 1;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Menu walk: selection wraps both ways, both back encodings, step before click.
    send_poll(STEP_FWD, 1'b0, 1'b1);
    send_poll(STEP_BACK, 1'b0, 1'b0);
    send_poll(STEP_ALT_BACK, 1'b0, 1'b1);
    send_poll(STEP_FWD, 1'b1, 1'b0);
    send_poll(STEP_FWD, 1'b0, 1'b1);
    send_poll(STEP_ALT_BACK, 1'b0, 1'b0);
    send_poll(STEP_BACK, 1'b0, 1'b1);
    send_poll(STEP_FWD, 1'b1, 1'b0);
    send_poll(STEP_FWD, 1'b1, 1'b0);
    send_poll(STEP_BACK, 1'b0, 1'b1);
    send_poll(STEP_ALT_BACK, 1'b0, 1'b0);
    send_poll(STEP_BACK, 1'b0, 1'b1);
    send_poll(STEP_FWD, 1'b1, 1'b0);
    send_poll(STEP_FWD, 1'b0, 1'b1);
    send_poll(STEP_FWD, 1'b0, 1'b1);
    send_poll(STEP_FWD, 1'b0, 1'b0);
    send_poll(STEP_ALT_BACK, 1'b1, 1'b1);
    send_poll(STEP_BACK, 1'b0, 1'b1);
    send_poll(STEP_BACK, 1'b0, 1'b0);
    send_poll(STEP_FWD, 1'b1, 1'b1);
    send_poll(STEP_FWD, 1'b0, 1'b1);
    send_poll(STEP_NONE, 1'b1, 1'b1);
    send_poll(STEP_FWD, 1'b0, 1'b0);
    send_poll(STEP_BACK, 1'b1, 1'b1);
    send_poll(STEP_NONE, 1'b1, 1'b0);

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: ;
        1: write_alarm_limits(8'd0, emssc_pkg::ANGLE_MAX);
        2: write_alarm_limits(emssc_pkg::MANUAL_HOME, emssc_pkg::MANUAL_HOME);
        3: write_alarm_limits(emssc_pkg::ANGLE_MAX, 8'd0);
        4: write_alarm_limits(8'd70, 8'd100);
        default: write_alarm_limits(8'($urandom_range(0, 180)), 8'($urandom_range(0, 180)));
      endcase
      case (phase)
        0: begin
          manual_run(100, 1, 100);
          manual_run(30, -1, 70);
        end
        1: pause_soak();
        2: begin
          settings_run(SET_NARROW_FAST);
          sweep_run(340, 100, 1'b0);
        end
        3: begin
          settings_run(SET_CEILING);
          sweep_run(40, 100, 1'b1);
          settings_run(SET_FLOOR);
        end
        4: manual_run(100, -1, 100);
        default: squeeze_output();
      endcase
      quota = DIRECTED_POLLS + (phase + 1) * RANDOM_POLLS / PHASES;
      while (polls_sent < quota) run_random_sequence();
    end

    @(negedge clk);
    in_valid <= 1'b0;
    waited = 0;
    while (expected_left != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (8) @(negedge clk);

    $display("Sent %0d encoder polls under %0d alarm threshold settings; %0d results compared.",
             polls_sent, alarm_settings, results_seen);
    $display("Covered menu walks, manual travel to both end stops, setting clamps, sweep reversals.");
    if (expected_left != 0) $display("%0d expected result words never arrived", expected_left);
    if (mismatch_count == 0 && expected_left == 0) begin
      $display("tb_encoder_menu_servo_sweep_controller_unit passed");
    end else begin
      $display("tb_encoder_menu_servo_sweep_controller_unit failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/emssc_pkg.sv
hw/rtl/encoder_menu_servo_sweep_controller_unit.sv
hw/rtl/emssc_checker.sv
bench/emssc_sweep_checker.sv
bench/tb_encoder_menu_servo_sweep_controller_unit.sv
